FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the record start conditioner RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is asserted.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/core/rsdf_pkg.sv
// Types and constants for the record start discard and fade-in block.
// No dependencies; imported by every other RTL file but assert_macros.svh.
`default_nettype none

package rsdf_pkg;

  localparam int SampleW  = 16;
  localparam int TotalW   = 32;
  localparam int CfgW     = 8;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam logic [CfgW-1:0] DiscardReset = 8'd2;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_START  = 1'b1
  } func_e;

  // Register index, taken from paddr above the byte offset.
  typedef enum logic {
    REG_DISCARD_CHUNKS = 1'b0
  } reg_idx_e;

  // Per-request decision from the control unit.
  typedef struct packed {
    logic              emit;
    logic              fading;
    logic [TotalW-1:0] total;
  } step_t;

  // Sideband carried alongside the scaling pipeline.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [TotalW-1:0]         total;
    logic                      last;
    logic                      fading;
    logic                      neg;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsdf_if.sv
// Valid/ready stream interfaces for sample requests and results.
// Depends on rsdf_pkg.
`default_nettype none

interface rsdf_in_if;
  import rsdf_pkg::*;
  logic                      valid;
  logic                      ready;
  func_e                     func;
  logic signed [SampleW-1:0] sample_in;
  logic                      chunk_end;

  modport source (output valid, func, sample_in, chunk_end, input ready);
  modport sink   (input valid, func, sample_in, chunk_end, output ready);
endinterface

interface rsdf_out_if;
  import rsdf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_out;
  logic [TotalW-1:0]         written_total;
  logic                      last_of_chunk;

  modport source (output valid, sample_out, written_total, last_of_chunk, input ready);
  modport sink   (input valid, sample_out, written_total, last_of_chunk, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rsdf_ctrl.sv
// Control unit: discard_chunks register (APB), discard, fade and total counters.
// Depends on rsdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rsdf_ctrl #(
  parameter int FADE_SAMPLES = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               acc_i,
  input  wire rsdf_pkg::func_e                    func_i,
  input  wire logic                               chunk_end_i,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rsdf_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [rsdf_pkg::ApbDataW-1:0]      pwdata,
  output logic      [rsdf_pkg::ApbDataW-1:0]      prdata,
  output logic                                    pready,
  output rsdf_pkg::step_t                         step_o,
  output logic      [$clog2(FADE_SAMPLES)-1:0]    done_o
);
  import rsdf_pkg::*;

  localparam int DoneW = $clog2(FADE_SAMPLES);
  localparam int FadeW = $clog2(FADE_SAMPLES + 1);
  localparam logic [FadeW-1:0] FadeInit = FadeW'(FADE_SAMPLES);

  logic [CfgW-1:0]   discard_chunks_q, discard_chunks_d;
  logic [CfgW-1:0]   discard_left_q, discard_left_d;
  logic [FadeW-1:0]  fade_left_q, fade_left_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [FadeW-1:0]  done_full;
  logic              cfg_wr;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1]);

  always_comb begin
    case (reg_idx)
      REG_DISCARD_CHUNKS: prdata = ApbDataW'(discard_chunks_q);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    discard_chunks_d = discard_chunks_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_DISCARD_CHUNKS: discard_chunks_d = pwdata[CfgW-1:0];
        default:            ;
      endcase
    end
  end

  // Decision for the request at the input, valid whenever acc_i is high.
  assign done_full = FadeInit - fade_left_q;
  assign done_o    = done_full[DoneW-1:0];

  always_comb begin
    step_o.emit   = (func_i == FUNC_SAMPLE) && (discard_left_q == '0);
    step_o.fading = (fade_left_q != '0);
    step_o.total  = total_q + TotalW'(1);
  end

  always_comb begin
    discard_left_d = discard_left_q;
    fade_left_d    = fade_left_q;
    total_d        = total_q;
    if (acc_i) begin
      case (func_i)
        FUNC_START: begin
          total_d        = '0;
          discard_left_d = discard_chunks_q;
          fade_left_d    = FadeInit;
        end
        FUNC_SAMPLE: begin
          if (discard_left_q != '0) begin
            // count a whole chunk off on its last sample
            if (chunk_end_i) discard_left_d = discard_left_q - CfgW'(1);
          end else begin
            if (fade_left_q != '0) fade_left_d = fade_left_q - FadeW'(1);
            total_d = total_q + TotalW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discard_chunks_q <= DiscardReset;
      discard_left_q   <= '0;
      fade_left_q      <= '0;
      total_q          <= '0;
    end else begin
      discard_chunks_q <= discard_chunks_d;
      discard_left_q   <= discard_left_d;
      fade_left_q      <= fade_left_d;
      total_q          <= total_d;
    end
  end

  `ASSERT_AT(a_start_reload, clk_i, rst_ni,
    acc_i && (func_i == FUNC_START) |=> (fade_left_q == FadeInit) && (total_q == '0),
    "start request did not reload fade and total counters")
  `ASSERT_AT(a_total_step, clk_i, rst_ni,
    acc_i && step_o.emit |=> total_q == $past(total_q) + TotalW'(1),
    "written total did not advance on a passed sample")

endmodule

`default_nettype wire

FILE: rtl/core/rsdf_fade.sv
// Fade datapath: six-stage pipeline that scales samples by done/FADE_SAMPLES.
// Depends on rsdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rsdf_fade #(
  parameter int FADE_SAMPLES = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   load_i,
  output logic                                        in_ready_o,
  input  wire logic signed [rsdf_pkg::SampleW-1:0]    sample_i,
  input  wire logic                                   last_i,
  input  wire rsdf_pkg::step_t                        step_i,
  input  wire logic        [$clog2(FADE_SAMPLES)-1:0] done_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [rsdf_pkg::SampleW-1:0]    sample_o,
  output logic             [rsdf_pkg::TotalW-1:0]     total_o,
  output logic                                        last_o
);
  import rsdf_pkg::*;

  localparam int NStage = 6;
  localparam int DoneW  = $clog2(FADE_SAMPLES);
  localparam int FW     = $clog2(FADE_SAMPLES + 1);
  localparam int MagW   = SampleW + DoneW;
  localparam int LoW    = MagW / 2;
  localparam int HiW    = MagW - LoW;
  localparam int PW     = SampleW + FW;
  // floor(2^MagW / F): product error stays below one, so one correction step
  localparam longint unsigned RecipL = (64'd1 << MagW) / 64'(FADE_SAMPLES);
  localparam logic [MagW-1:0] Recip  = MagW'(RecipL);
  localparam logic [FW-1:0]   FConst = FW'(FADE_SAMPLES);

  logic [NStage-1:0] vld_q, adv;

  side_t                 side0_q, side1_q, side2_q, side3_q, side4_q, side0_d;
  logic [SampleW-1:0]    abs0_q, abs0_d;
  logic [DoneW-1:0]      done0_q;
  logic [MagW-1:0]       mag1_q, mag2_q, mag3_q, mag4_q;
  logic [HiW+MagW-1:0]   pph2_q;
  logic [LoW+MagW-1:0]   ppl2_q;
  logic [2*MagW-1:0]     sum3;
  logic [SampleW-1:0]    qest3_q, qest4_q;
  logic [PW-1:0]         prod_full;
  logic [MagW-1:0]       prod4_q;
  logic [MagW-1:0]       rem;
  logic [SampleW-1:0]    quot, scaled;
  logic signed [SampleW-1:0] sample5_q;
  logic [TotalW-1:0]     total5_q;
  logic                  last5_q;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    adv[NStage-1] = !vld_q[NStage-1] || out_ready_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= load_i;
      for (int k = 1; k < NStage; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0: capture sample, magnitude and ramp position.
  always_comb begin
    side0_d.sample = sample_i;
    side0_d.total  = step_i.total;
    side0_d.last   = last_i;
    side0_d.fading = step_i.fading;
    side0_d.neg    = sample_i[SampleW-1];
    abs0_d = sample_i[SampleW-1] ? (~sample_i + SampleW'(1)) : sample_i;
  end

  assign sum3      = {pph2_q, {LoW{1'b0}}} + (2*MagW)'(ppl2_q);
  assign prod_full = PW'(qest3_q) * PW'(FConst);
  assign rem       = mag4_q - prod4_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side0_q <= side0_d;
      abs0_q  <= abs0_d;
      done0_q <= done_i;
    end
    if (adv[1]) begin
      side1_q <= side0_q;
      mag1_q  <= MagW'(abs0_q) * MagW'(done0_q);
    end
    if (adv[2]) begin
      side2_q <= side1_q;
      mag2_q  <= mag1_q;
      pph2_q  <= (HiW+MagW)'(mag1_q[MagW-1:LoW]) * (HiW+MagW)'(Recip);
      ppl2_q  <= (LoW+MagW)'(mag1_q[LoW-1:0]) * (LoW+MagW)'(Recip);
    end
    if (adv[3]) begin
      side3_q <= side2_q;
      mag3_q  <= mag2_q;
      qest3_q <= sum3[MagW+SampleW-1:MagW];
    end
    if (adv[4]) begin
      side4_q <= side3_q;
      mag4_q  <= mag3_q;
      qest4_q <= qest3_q;
      prod4_q <= prod_full[MagW-1:0];
    end
    if (adv[5]) begin
      sample5_q <= side4_q.fading ? scaled : side4_q.sample;
      total5_q  <= side4_q.total;
      last5_q   <= side4_q.last;
    end
  end

  // Correct the quotient estimate by one, then restore the sign (truncate toward zero).
  always_comb begin
    quot   = qest4_q + SampleW'(rem >= MagW'(FConst));
    scaled = side4_q.neg ? (~quot + SampleW'(1)) : quot;
  end

  assign out_valid_o = vld_q[NStage-1];
  assign sample_o    = sample5_q;
  assign total_o     = total5_q;
  assign last_o      = last5_q;

  `ASSERT_NEVER(a_rem_bound, clk_i, rst_ni,
    vld_q[4] && side4_q.fading && (32'(rem) >= 32'(2 * FADE_SAMPLES)),
    "quotient estimate off by more than one")
  `ASSERT_AT(a_stall_full, clk_i, rst_ni,
    !adv[0] |-> (&vld_q),
    "input stalled while the pipeline has a bubble")

endmodule

`default_nettype wire

FILE: rtl/core/record_startup_discard_fade_in_top.sv
// Recording start conditioner: drops the first discard_chunks whole chunks after
// a start request, then ramps the next FADE_SAMPLES samples up linearly, and
// passes later samples through with a running written-sample count. One request
// is taken every clock cycle unless the result side stalls with all six pipeline
// stages full; a passed sample runs through the scaling pipeline before it is
// presented (sample times ramp position, reciprocal multiply in two partial
// products, quotient correction, result register). Start requests and discarded
// samples give no result. Depends on rsdf_pkg, rsdf_if, rsdf_ctrl, rsdf_fade.
`default_nettype none

module record_startup_discard_fade_in_top #(
  parameter int FADE_SAMPLES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rsdf_in_if.sink                            sample_i,
  rsdf_out_if.source                         result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rsdf_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [rsdf_pkg::ApbDataW-1:0] pwdata,
  output logic      [rsdf_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import rsdf_pkg::*;

  localparam int DoneW = $clog2(FADE_SAMPLES);

  logic             in_ready;
  logic             acc;
  step_t            step;
  logic [DoneW-1:0] done;

  assign sample_i.ready = in_ready;
  assign acc            = sample_i.valid && in_ready;

  rsdf_ctrl #(
    .FADE_SAMPLES (FADE_SAMPLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .func_i      (sample_i.func),
    .chunk_end_i (sample_i.chunk_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .step_o      (step),
    .done_o      (done)
  );

  rsdf_fade #(
    .FADE_SAMPLES (FADE_SAMPLES)
  ) u_fade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc && step.emit),
    .in_ready_o  (in_ready),
    .sample_i    (sample_i.sample_in),
    .last_i      (sample_i.chunk_end),
    .step_i      (step),
    .done_i      (done),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sample_o    (result_o.sample_out),
    .total_o     (result_o.written_total),
    .last_o      (result_o.last_of_chunk)
  );

endmodule

`default_nettype wire

FILE: test/tb_record_startup_discard_fade_in_top.sv
// Self-checking testbench for record_startup_discard_fade_in_top: directed table, then
// random recordings with random gaps and stalls, checked against an in-bench predictor.
// Depends on rsdf_pkg and rsdf_if from the RTL.
`default_nettype none

module tb_record_startup_discard_fade_in_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsdf_pkg::*;

  localparam int FadeLen     = 1024;
  localparam int DrainCycles = 12;
  localparam int QuietLimit  = 2000;
  localparam int MaxReports  = 100;

  localparam logic [ApbAddrW-1:0] DiscardAddr  = ApbAddrW'(int'(REG_DISCARD_CHUNKS) * 4);
  localparam logic [ApbAddrW-1:0] UnmappedAddr = ApbAddrW'((int'(REG_DISCARD_CHUNKS) + 1) * 4);

  typedef struct packed {
    logic signed [SampleW-1:0] smp;
    logic [TotalW-1:0]         tot;
    logic                      last;
  } fade_result_t;

  typedef struct packed {
    func_e             func;
    logic [SampleW-1:0] smp;
    logic              ce;
    logic              typed;
    logic [SampleW-1:0] want_smp;
    logic [TotalW-1:0]  want_tot;
  } dir_row_t;

  // Expected values typed in for the pass-through, first-ramp and restart rows.
  localparam dir_row_t DirTab [20] = '{
    '{FUNC_SAMPLE, 16'h7fff, 1'b0, 1'b1, 16'h7fff, 32'd1},
    '{FUNC_SAMPLE, 16'h8000, 1'b1, 1'b1, 16'h8000, 32'd2},
    '{FUNC_SAMPLE, 16'h0000, 1'b0, 1'b1, 16'h0000, 32'd3},
    '{FUNC_SAMPLE, 16'hffff, 1'b1, 1'b1, 16'hffff, 32'd4},
    '{FUNC_START,  16'h5a5a, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h04d2, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'hfffb, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h0309, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h7fff, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h7fff, 1'b0, 1'b1, 16'h0000, 32'd1},
    '{FUNC_SAMPLE, 16'h7fff, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h8000, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'hffff, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'hfc18, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_START,  16'ha5a5, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h0064, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_START,  16'h0000, 1'b0, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h0064, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h0064, 1'b1, 1'b0, 16'h0000, 32'd0},
    '{FUNC_SAMPLE, 16'h8000, 1'b1, 1'b1, 16'h0000, 32'd1}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  rsdf_in_if  req_if ();
  rsdf_out_if res_if ();

  record_startup_discard_fade_in_top #(
    .FADE_SAMPLES(FadeLen)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(req_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [CfgW-1:0]   discard_cfg = DiscardReset;
  logic [CfgW-1:0]   chunks_to_drop = '0;
  int                ramp_left = 0;
  logic [TotalW-1:0] written_cnt = '0;

  fade_result_t pending_fades[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;
  fade_result_t seen;

  task automatic flag_mismatch(input string what);
    if (mismatches < MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic bit fade_predict(input func_e f, input logic signed [SampleW-1:0] smp,
                                      input logic ce, output fade_result_t r);
    int scaled;
    r = '0;
    if (f == FUNC_START) begin
      written_cnt    = '0;
      chunks_to_drop = discard_cfg;
      ramp_left      = FadeLen;
      return 1'b0;
    end
    if (chunks_to_drop != '0) begin
      if (ce) begin
        chunks_to_drop--;
      end
      return 1'b0;
    end
    scaled = int'(smp);
    if (ramp_left != 0) begin
      // C-style division: truncate toward zero
      scaled = (scaled * (FadeLen - ramp_left)) / FadeLen;
      ramp_left--;
    end
    written_cnt++;
    r.smp  = scaled[SampleW-1:0];
    r.tot  = written_cnt;
    r.last = ce;
    return 1'b1;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_req(input func_e f, input logic [SampleW-1:0] smp, input logic ce,
                          input logic typed, input fade_result_t typed_res);
    int           gap;
    fade_result_t r;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.sample_in <= smp;
    req_if.chunk_end <= ce;
    do @(posedge clk_i); while (!req_if.ready);
    if (fade_predict(f, smp, ce, r)) begin
      pending_fades.push_back(typed ? typed_res : r);
    end
  endtask

  task automatic send_sample(input logic ce);
    send_req(FUNC_SAMPLE, SampleW'($urandom()), ce, 1'b0, '0);
  endtask

  // Drop valid, collect every outstanding result, then cover the pipeline depth.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_fades.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] data, output logic [ApbDataW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register and read the discard setting back.
  task automatic cfg_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b1, addr, data, rd);
    if (addr == DiscardAddr) begin
      discard_cfg = data[CfgW-1:0];
    end
    apb_access(1'b0, DiscardAddr, '0, rd);
    if (rd != ApbDataW'(discard_cfg)) begin
      flag_mismatch($sformatf("discard_chunks read %0h, want %0h", rd, discard_cfg));
    end
  endtask

  // One recording: new discard setting, start request, then samples; noisy runs
  // throw in stray start requests.
  task automatic run_recording(input int chunks, input int n, input int ce_weight,
                               input bit noisy);
    drain();
    cfg_write(DiscardAddr, {24'($urandom_range(0, 32'h00ff_ffff)), 8'(chunks)});
    calm = ($urandom_range(0, 2) == 0);
    send_req(FUNC_START, SampleW'($urandom()), 1'($urandom()), 1'b0, '0);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_req(FUNC_START, SampleW'($urandom()), 1'($urandom()), 1'b0, '0);
      end else begin
        send_sample($urandom_range(0, 7) < ce_weight);
      end
    end
  endtask

  // Result sink with random stalls
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && rst_ni));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_fades.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sample %0d total %0d",
                                res_if.sample_out, res_if.written_total));
      end else begin
        seen = pending_fades.pop_front();
        if (res_if.sample_out !== seen.smp) begin
          flag_mismatch($sformatf("sample_out %0d, want %0d (total %0d)",
                                  res_if.sample_out, seen.smp, seen.tot));
        end
        if (res_if.written_total !== seen.tot) begin
          flag_mismatch($sformatf("written_total %0d, want %0d",
                                  res_if.written_total, seen.tot));
        end
        if (res_if.last_of_chunk !== seen.last) begin
          flag_mismatch($sformatf("last_of_chunk %0b, want %0b (total %0d)",
                                  res_if.last_of_chunk, seen.last, seen.tot));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("tb_record_startup_discard_fade_in_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [ApbDataW-1:0] rd;
    req_if.valid     <= 1'b0;
    req_if.func      <= FUNC_SAMPLE;
    req_if.sample_in <= '0;
    req_if.chunk_end <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the discard setting
    apb_access(1'b0, DiscardAddr, '0, rd);
    if (rd != ApbDataW'(DiscardReset)) begin
      flag_mismatch($sformatf("discard_chunks after reset %0h", rd));
    end

    foreach (DirTab[i]) begin
      send_req(DirTab[i].func, DirTab[i].smp, DirTab[i].ce, DirTab[i].typed,
               '{DirTab[i].want_smp, DirTab[i].want_tot, DirTab[i].ce});
    end

    // Zero discard: full ramp and then pass-through
    run_recording(0, 1030, 1, 1'b0);
    // Largest discard, every sample ends a chunk: all of them are dropped
    run_recording(255, 40, 8, 1'b0);

    // Write to an unmapped index must leave the setting alone
    drain();
    cfg_write(UnmappedAddr, $urandom());

    for (int k = 0; k < 6; k++) begin
      run_recording($urandom_range(0, 2), $urandom_range(8, 16), 4, 1'b1);
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_record_startup_discard_fade_in_top OK");
    end else begin
      $display("tb_record_startup_discard_fade_in_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: record_startup_discard_fade_in_top.f
+incdir+rtl/core
rtl/core/rsdf_pkg.sv
rtl/core/rsdf_if.sv
rtl/core/rsdf_ctrl.sv
rtl/core/rsdf_fade.sv
rtl/core/record_startup_discard_fade_in_top.sv
test/tb_record_startup_discard_fade_in_top.sv
